>>> src/line_position_steering_drive_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for line_position_steering_drive
// Clocked implication checks with a common reset qualifier.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_STEERING_DRIVE_MACROS_SVH
`define LINE_POSITION_STEERING_DRIVE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define LPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsd: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LPSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsd: same-cycle check failed");

`endif

>>> src/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Widths, constants, register codes and stage types of the steering drive.
// ----------------------------------------------------------------------------
package lpsd_pkg;

    localparam int FRACTION_BITS = 12;

    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 3;
    localparam int KIND_W   = 9;
    localparam int POS_W    = 16;
    localparam int DUTY_W   = 13;
    localparam int CENTER_W = 10;
    localparam int BASE_W   = 14;
    localparam int GAIN_W   = 12;
    localparam int ERR_W    = POS_W + 1;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;
    localparam int SHIFT    = 8;
    localparam int DELTA_W  = PROD_W - SHIFT;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BASE_W;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 80;

    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h71;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // Byte positions inside a message that are stored
    localparam logic [IDX_W-1:0] IDX_KIND  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_HUND  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_TENS  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_UNIT  = 3'd4;
    localparam logic [IDX_W-1:0] INDEX_MAX = 3'd7;

    localparam logic [CENTER_W-1:0]      CENTER_RESET = 10'd256;
    localparam logic signed [BASE_W-1:0] BASE_RESET   = 14'sd2376;
    localparam logic [GAIN_W-1:0]        GAIN_RESET   = 12'd205;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER = 2'd0,
        REG_BASE   = 2'd1,
        REG_GAIN   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [KIND_W-1:0] kind;
        logic signed [POS_W-1:0]  pos;
    } line_t;

    typedef struct packed {
        logic signed [KIND_W-1:0] kind;
        logic signed [POS_W-1:0]  pos;
        logic signed [PROD_W-1:0] prod;
    } steer_t;

    typedef struct packed {
        logic signed [KIND_W-1:0] kind;
        logic signed [POS_W-1:0]  pos;
        logic [DUTY_W-1:0]        right_fwd;
        logic [DUTY_W-1:0]        right_rev;
        logic [DUTY_W-1:0]        left_fwd;
        logic [DUTY_W-1:0]        left_rev;
    } result_t;

endpackage

>>> src/lpsd_decode.sv
// ----------------------------------------------------------------------------
// lpsd_decode
// Message byte store and line decode; emits one line beat per terminator.
// ----------------------------------------------------------------------------
`include "line_position_steering_drive_macros.svh"

module lpsd_decode (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lpsd_pkg::BYTE_W-1:0]       in_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpsd_pkg::line_t                   out_line
);

    logic [lpsd_pkg::IDX_W-1:0]             idx_reg, idx_next;
    logic [3:0][lpsd_pkg::BYTE_W-1:0]       msg_reg, msg_next;
    logic                                   valid_reg, valid_next;
    lpsd_pkg::line_t                        line_reg, line_next;

    logic                                   in_fire;
    logic                                   is_term;
    logic signed [lpsd_pkg::KIND_W-1:0]     dig_h, dig_t, dig_u;
    logic signed [lpsd_pkg::POS_W-1:0]      ext_h, ext_t, ext_u;

    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_term  = (in_byte == lpsd_pkg::TERMINATOR);

    always_comb begin
        idx_next = idx_reg;
        msg_next = msg_reg;
        if (in_fire) begin
            if (is_term) begin
                idx_next = '0;
            end else begin
                case (idx_reg)
                    lpsd_pkg::IDX_KIND: msg_next[0] = in_byte;
                    lpsd_pkg::IDX_HUND: msg_next[1] = in_byte;
                    lpsd_pkg::IDX_TENS: msg_next[2] = in_byte;
                    lpsd_pkg::IDX_UNIT: msg_next[3] = in_byte;
                    default: ;
                endcase
                // saturate so long messages never wrap onto stored slots
                if (idx_reg != lpsd_pkg::INDEX_MAX) begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    // Terminator is never stored, so decode straight from the held slots
    assign dig_h = $signed({1'b0, msg_reg[1]}) - $signed({1'b0, lpsd_pkg::ASCII_ZERO});
    assign dig_t = $signed({1'b0, msg_reg[2]}) - $signed({1'b0, lpsd_pkg::ASCII_ZERO});
    assign dig_u = $signed({1'b0, msg_reg[3]}) - $signed({1'b0, lpsd_pkg::ASCII_ZERO});
    assign ext_h = {{(lpsd_pkg::POS_W-lpsd_pkg::KIND_W){dig_h[lpsd_pkg::KIND_W-1]}}, dig_h};
    assign ext_t = {{(lpsd_pkg::POS_W-lpsd_pkg::KIND_W){dig_t[lpsd_pkg::KIND_W-1]}}, dig_t};
    assign ext_u = {{(lpsd_pkg::POS_W-lpsd_pkg::KIND_W){dig_u[lpsd_pkg::KIND_W-1]}}, dig_u};

    always_comb begin
        valid_next = valid_reg;
        line_next  = line_reg;
        if (in_ready) begin
            valid_next     = in_fire && is_term;
            line_next.kind = $signed({1'b0, msg_reg[0]})
                             - $signed({1'b0, lpsd_pkg::ASCII_ZERO});
            line_next.pos  = ext_h * 16'sd100 + ext_t * 16'sd10 + ext_u;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            msg_reg   <= {4{lpsd_pkg::ASCII_ZERO}};
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            msg_reg   <= msg_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg <= line_next;
    end

    assign out_valid = valid_reg;
    assign out_line  = line_reg;

    `LPSD_ASSERT_NEXT(a_term_clears_index, aclk, aresetn, in_fire && is_term, idx_reg == '0)
    `LPSD_ASSERT_NEXT(a_tail_keeps_slots, aclk, aresetn, in_fire && (idx_reg > lpsd_pkg::IDX_UNIT), msg_reg == $past(msg_reg))
    `LPSD_ASSERT_SAME(a_line_from_term, aclk, aresetn, $rose(valid_reg), $past(in_fire && is_term))

endmodule

>>> src/lpsd_steer.sv
// ----------------------------------------------------------------------------
// lpsd_steer
// Position error times steering gain, registered.
// ----------------------------------------------------------------------------
module lpsd_steer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lpsd_pkg::CENTER_W-1:0]     center,
    input  logic [lpsd_pkg::GAIN_W-1:0]       gain,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lpsd_pkg::line_t                   in_line,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpsd_pkg::steer_t                  out_steer
);

    logic                                  valid_reg, valid_next;
    lpsd_pkg::steer_t                      steer_reg, steer_next;
    logic signed [lpsd_pkg::ERR_W-1:0]     err;
    logic signed [lpsd_pkg::GAIN_W:0]      gain_s;

    assign in_ready = !valid_reg || out_ready;

    assign err = {in_line.pos[lpsd_pkg::POS_W-1], in_line.pos}
                 - $signed({{(lpsd_pkg::ERR_W-lpsd_pkg::CENTER_W){1'b0}}, center});
    assign gain_s = $signed({1'b0, gain});

    always_comb begin
        valid_next = valid_reg;
        steer_next = steer_reg;
        if (in_ready) begin
            valid_next      = in_valid;
            steer_next.kind = in_line.kind;
            steer_next.pos  = in_line.pos;
            steer_next.prod = err * gain_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steer_reg <= steer_next;
    end

    assign out_valid = valid_reg;
    assign out_steer = steer_reg;

endmodule

>>> src/lpsd_drive.sv
// ----------------------------------------------------------------------------
// lpsd_drive
// Motor powers, clamp and H-bridge duty pairs into the result register.
// ----------------------------------------------------------------------------
module lpsd_drive #(
    parameter int FRACTION_BITS = lpsd_pkg::FRACTION_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic signed [lpsd_pkg::BASE_W-1:0] base,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lpsd_pkg::steer_t                  in_steer,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpsd_pkg::result_t                 out_result
);

    localparam int PWR_W = (lpsd_pkg::DELTA_W + 1 > FRACTION_BITS + 2)
                           ? lpsd_pkg::DELTA_W + 1 : FRACTION_BITS + 2;
    localparam logic signed [PWR_W-1:0] ONE     = PWR_W'(1) << FRACTION_BITS;
    localparam logic signed [PWR_W-1:0] NEG_ONE = -ONE;

    logic                                   valid_reg, valid_next;
    lpsd_pkg::result_t                      res_reg, res_next;
    logic signed [lpsd_pkg::PROD_W-1:0]     prod_shr;
    logic signed [lpsd_pkg::DELTA_W-1:0]    delta;
    logic signed [PWR_W-1:0]                delta_x, base_x, right_pwr, left_pwr;
    logic [2*lpsd_pkg::DUTY_W-1:0]          right_pair, left_pair;

    // Returns {rev, fwd}
    function automatic logic [2*lpsd_pkg::DUTY_W-1:0] duty_pair(
        input logic signed [PWR_W-1:0] pwr
    );
        logic signed [PWR_W-1:0] c;
        logic signed [PWR_W-1:0] f;
        logic signed [PWR_W-1:0] r;
        c = pwr;
        if (pwr > ONE) begin
            c = ONE;
        end else if (pwr < NEG_ONE) begin
            c = NEG_ONE;
        end
        if (c > $signed(PWR_W'(0))) begin
            f = ONE;
            r = ONE - c;
        end else begin
            r = ONE;
            f = ONE + c;
        end
        return {r[lpsd_pkg::DUTY_W-1:0], f[lpsd_pkg::DUTY_W-1:0]};
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // floor divide by 256
    assign prod_shr = $signed(in_steer.prod) >>> lpsd_pkg::SHIFT;
    assign delta    = prod_shr[lpsd_pkg::DELTA_W-1:0];
    assign delta_x = PWR_W'(delta);
    assign base_x  = PWR_W'(base);
    assign right_pwr = base_x + delta_x;
    assign left_pwr  = base_x - delta_x;
    assign right_pair = duty_pair(right_pwr);
    assign left_pair  = duty_pair(left_pwr);

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next         = in_valid;
            res_next.kind      = in_steer.kind;
            res_next.pos       = in_steer.pos;
            res_next.right_fwd = right_pair[lpsd_pkg::DUTY_W-1:0];
            res_next.right_rev = right_pair[2*lpsd_pkg::DUTY_W-1:lpsd_pkg::DUTY_W];
            res_next.left_fwd  = left_pair[lpsd_pkg::DUTY_W-1:0];
            res_next.left_rev  = left_pair[2*lpsd_pkg::DUTY_W-1:lpsd_pkg::DUTY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

endmodule

>>> src/line_position_steering_drive.sv
// A terminator's result beat passes the decode, steer and drive registers in turn.
// Throughput: one byte per cycle while s_tready is high; the three registered stages
// (decode, gain multiply, clamp and duty) each advance whenever the stage after them is
// empty or drained. Bytes other than the terminator produce no result beat.
// Reset (aresetn low, synchronous): byte index to zero, stored slots to ASCII '0',
// registers to their defaults, all stages empty.
// ----------------------------------------------------------------------------
// line_position_steering_drive
// Line tracker message decode with proportional steering of two H-bridges.
// ----------------------------------------------------------------------------
module line_position_steering_drive #(
    parameter int FRACTION_BITS = lpsd_pkg::FRACTION_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpsd_pkg::S_DATA_W-1:0]        s_tdata,   // [7:0] rx_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [8:0] line_kind, [24:9] line_position, [37:25] right_duty_fwd,
    // [50:38] right_duty_rev, [63:51] left_duty_fwd, [76:64] left_duty_rev
    output logic [lpsd_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [lpsd_pkg::CENTER_W-1:0]        center_reg, center_next;
    logic signed [lpsd_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [lpsd_pkg::GAIN_W-1:0]          gain_reg, gain_next;

    logic               line_valid, line_ready;
    lpsd_pkg::line_t    line_beat;
    logic               steer_valid, steer_ready;
    lpsd_pkg::steer_t   steer_beat;
    lpsd_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    always_comb begin
        center_next = center_reg;
        base_next   = base_reg;
        gain_next   = gain_reg;
        if (cfg_valid) begin
            case (lpsd_pkg::cfg_reg_t'(cfg_index))
                lpsd_pkg::REG_CENTER: center_next = cfg_data[lpsd_pkg::CENTER_W-1:0];
                lpsd_pkg::REG_BASE:   base_next   = $signed(cfg_data[lpsd_pkg::BASE_W-1:0]);
                lpsd_pkg::REG_GAIN:   gain_next   = cfg_data[lpsd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= lpsd_pkg::CENTER_RESET;
            base_reg   <= lpsd_pkg::BASE_RESET;
            gain_reg   <= lpsd_pkg::GAIN_RESET;
        end else begin
            center_reg <= center_next;
            base_reg   <= base_next;
            gain_reg   <= gain_next;
        end
    end

    lpsd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (line_valid),
        .out_ready (line_ready),
        .out_line  (line_beat)
    );

    lpsd_steer u_steer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .center    (center_reg),
        .gain      (gain_reg),
        .in_valid  (line_valid),
        .in_ready  (line_ready),
        .in_line   (line_beat),
        .out_valid (steer_valid),
        .out_ready (steer_ready),
        .out_steer (steer_beat)
    );

    lpsd_drive #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_drive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .base       (base_reg),
        .in_valid   (steer_valid),
        .in_ready   (steer_ready),
        .in_steer   (steer_beat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {3'b000,
                      result.left_rev, result.left_fwd,
                      result.right_rev, result.right_fwd,
                      result.pos, result.kind};

endmodule
